// File: rtl/porc_pkg.sv
// shared codes and handshake types for the path oram controller
// no dependencies
`default_nettype none

package porc_pkg;

	localparam int unsigned ADDR_IN_W = 10;
	localparam int unsigned DATA_W    = 32;

	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic clearing;
		logic done;
	} back_stat_t;

endpackage

`default_nettype wire

// File: rtl/porc_queue.sv
// two-entry command queue between front and back
// depends on nothing
`default_nettype none

module porc_queue #(
	parameter int unsigned W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              valid,
	output logic [W-1:0]      head_data
);

	logic [W-1:0] ent0_q, ent1_q;
	logic [1:0]   cnt_q;

	assign full      = cnt_q == 2'd2;
	assign valid     = cnt_q != 2'd0;
	assign head_data = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && valid) begin
			if (push && !full && cnt_q == 2'd1) ent0_q <= push_data;
			else ent0_q <= ent1_q;
			if (push && !full && cnt_q == 2'd2) ent1_q <= push_data;
		end else if (push && !full) begin
			if (cnt_q == 2'd0) ent0_q <= push_data;
			else ent1_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/porc_front.sv
// front: takes commands, reduces address and leaves, hands words to the queue
// depends on porc_pkg
`default_nettype none

module porc_front
	import porc_pkg::*;
#(
	parameter int unsigned TREE_LEVELS   = 8,
	parameter int unsigned ADDRESS_COUNT = 1024,
	parameter int unsigned QW            = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [9:0]         address,
	input  wire logic signed [31:0] write_data,
	input  wire logic [6:0]         new_leaf,
	input  wire logic [6:0]         dummy_leaf,
	input  wire logic [5:0]         extra_leaf,
	input  wire back_stat_t         stat,
	output logic                    push,
	output logic [QW-1:0]           push_data,
	input  wire logic               q_full
);

	localparam int unsigned LW         = TREE_LEVELS - 1;
	localparam int unsigned AW         = $clog2(ADDRESS_COUNT);
	localparam int unsigned LEAF_TOTAL = 1 << LW;
	localparam int unsigned LEAF_HALF  = LEAF_TOTAL / 2;

	logic                 hold_q;
	logic                 act_q;
	logic [ADDR_IN_W-1:0] red_q;
	logic [DATA_W-1:0]    wd_q;
	logic [LW-1:0]        nl_q, dl_q, xl_q;
	logic                 in_range;
	logic                 take;

	assign in_range  = 17'(red_q) < 17'(ADDRESS_COUNT);
	assign busy      = hold_q || stat.clearing;
	assign take      = start && !busy;
	assign push      = hold_q && in_range && !q_full;
	assign push_data = {act_q, AW'(red_q), wd_q, nl_q, dl_q, xl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (take) begin
			hold_q <= 1'b1;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= action;
			red_q <= address;
			wd_q  <= write_data;
			nl_q  <= LW'(16'(new_leaf) & 16'(LEAF_TOTAL - 1));
			dl_q  <= LW'(16'(dummy_leaf) & 16'(LEAF_TOTAL - 1));
			xl_q  <= LW'(16'(extra_leaf) & 16'(LEAF_HALF - 1));
		end else if (hold_q && !in_range) begin
			// repeated subtract, only reachable when the map is smaller than the field
			red_q <= red_q - ADDR_IN_W'(ADDRESS_COUNT);
		end
	end

endmodule

`default_nettype wire

// File: rtl/porc_back.sv
// back: sequencer over position map, bucket tree, fill counts and stash
// depends on porc_pkg
`default_nettype none

module porc_back
	import porc_pkg::*;
#(
	parameter int unsigned TREE_LEVELS   = 8,
	parameter int unsigned BUCKET_SLOTS  = 4,
	parameter int unsigned STASH_DEPTH   = 64,
	parameter int unsigned ADDRESS_COUNT = 1024,
	parameter int unsigned QW            = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire logic [QW-1:0] q_data,
	output logic             q_pop,
	input  wire logic        capacity_we,
	input  wire logic [9:0]  capacity,
	output back_stat_t       stat,
	output logic [31:0]      rdata,
	output logic [1:0]       rstatus,
	output logic [6:0]       rpeak
);

	localparam int unsigned LW         = TREE_LEVELS - 1;
	localparam int unsigned NW         = TREE_LEVELS;
	localparam int unsigned AW         = $clog2(ADDRESS_COUNT);
	localparam int unsigned EW         = AW + DATA_W;
	localparam int unsigned NODE_TOTAL = (1 << TREE_LEVELS) - 1;
	localparam int unsigned SLOT_TOTAL = NODE_TOTAL * BUCKET_SLOTS;
	localparam int unsigned SIW        = $clog2(SLOT_TOTAL);
	localparam int unsigned FW         = $clog2(BUCKET_SLOTS + 1);
	localparam int unsigned SW         = $clog2(STASH_DEPTH);
	localparam int unsigned CW         = $clog2(STASH_DEPTH + 1);
	localparam int unsigned LVW        = $clog2(TREE_LEVELS);
	localparam int unsigned LEAF_HALF  = 1 << (LW - 1);

	typedef enum logic [18:0] {
		S_CLEAR  = 19'd1 << 0,
		S_IDLE   = 19'd1 << 1,
		S_MAPRD  = 19'd1 << 2,
		S_MAPCHK = 19'd1 << 3,
		S_RFILL  = 19'd1 << 4,
		S_RCAP   = 19'd1 << 5,
		S_RSLOT  = 19'd1 << 6,
		S_RPUSH  = 19'd1 << 7,
		S_RDONE  = 19'd1 << 8,
		S_MAPWR  = 19'd1 << 9,
		S_SRISS  = 19'd1 << 10,
		S_SRCHK  = 19'd1 << 11,
		S_EFILL  = 19'd1 << 12,
		S_ECAP   = 19'd1 << 13,
		S_EISS   = 19'd1 << 14,
		S_EMAP   = 19'd1 << 15,
		S_EDEC   = 19'd1 << 16,
		S_FIN    = 19'd1 << 17,
		S_DONE   = 19'd1 << 18
	} state_t;

	function automatic logic [SW-1:0] wrap(input logic [SW-1:0] b, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(o);
		if (s >= (CW+1)'(STASH_DEPTH)) s = s - (CW+1)'(STASH_DEPTH);
		return SW'(s);
	endfunction

	// memories
	logic [LW:0]       map_mem [ADDRESS_COUNT];
	logic [EW-1:0]     slot_mem [SLOT_TOTAL];
	logic [FW-1:0]     fill_mem [NODE_TOTAL];
	logic [EW-1:0]     stash_mem [STASH_DEPTH];
	logic              fill_vld_q [NODE_TOTAL];

	logic [LW:0]       map_rd;
	logic [EW-1:0]     slot_rd, stash_rd;
	logic [FW-1:0]     fill_rd;
	logic              fill_v_rd;

	logic              map_we;
	logic [AW-1:0]     map_wa, map_ra;
	logic [LW:0]       map_wd;
	logic              st_we;
	logic [SW-1:0]     st_wa, st_ra;
	logic [EW-1:0]     st_wd;
	logic              slot_we;
	logic [SIW-1:0]    slot_wa, slot_ra;
	logic              fill_we;
	logic [FW-1:0]     fill_wd;

	state_t            state_q;
	logic              act_q;
	logic [AW-1:0]     addr_q;
	logic [DATA_W-1:0] wd_q;
	logic [LW-1:0]     nl_q, dl_q, xl_q;
	logic [LW-1:0]     old_q;
	logic              pass2_q, newblk_q, ovf_q;
	logic [NW-1:0]     node1_q;
	logic [LVW-1:0]    lvl_q;
	logic [FW-1:0]     slot_i_q, fill_cur_q;
	logic [SW-1:0]     head_q;
	logic [CW-1:0]     cnt_q, drain_n_q, drain_i_q, srch_i_q;
	logic [EW-1:0]     e_q;
	logic [31:0]       rdata_q;
	logic [1:0]        status_q;
	logic [CW-1:0]     peak_q;
	logic [9:0]        stored_q, cap_q;
	logic [AW-1:0]     clr_q;

	logic [NW-1:0]     ni;
	logic [SIW-1:0]    node_base;
	logic [NW-1:0]     leaf_node1;
	logic              fits, match, stash_full, e_stop;
	logic [FW-1:0]     fill_eff;
	logic [LW-1:0]     second_leaf;

	assign ni          = node1_q - NW'(1);
	assign node_base   = SIW'(ni) * SIW'(BUCKET_SLOTS);
	assign leaf_node1  = {1'b1, map_rd[LW-1:0]};
	assign fits        = map_rd[LW] && ((leaf_node1 >> (LVW'(LW) - lvl_q)) == node1_q);
	assign match       = stash_rd[EW-1:DATA_W] == addr_q;
	assign stash_full  = cnt_q >= CW'(STASH_DEPTH);
	assign e_stop      = drain_i_q == drain_n_q || fill_cur_q >= FW'(BUCKET_SLOTS);
	assign fill_eff    = fill_v_rd ? fill_rd : '0;
	assign second_leaf = xl_q | (old_q[LW-1] ? LW'(0) : LW'(LEAF_HALF));

	assign stat.clearing = state_q == S_CLEAR;
	assign stat.done     = state_q == S_DONE;
	assign q_pop         = state_q == S_IDLE && q_valid;
	assign rdata         = rdata_q;
	assign rstatus       = status_q;
	assign rpeak         = 7'(peak_q);

	always_comb begin
		map_ra  = state_q == S_EMAP ? stash_rd[EW-1:DATA_W] : addr_q;
		map_we  = 1'b0;
		map_wa  = addr_q;
		map_wd  = {1'b1, nl_q};
		st_ra   = state_q == S_SRISS ? wrap(head_q, srch_i_q) : head_q;
		st_we   = 1'b0;
		st_wa   = wrap(head_q, cnt_q);
		st_wd   = e_q;
		slot_ra = node_base + SIW'(slot_i_q);
		slot_we = 1'b0;
		slot_wa = node_base + SIW'(fill_cur_q);
		fill_we = 1'b0;
		fill_wd = fill_cur_q;
		unique case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = '0;
			end
			S_MAPWR: map_we = 1'b1;
			S_RSLOT: begin
				if (slot_i_q >= fill_cur_q) begin
					fill_we = 1'b1;
					fill_wd = '0;
				end
			end
			S_RPUSH: begin
				st_we = !stash_full;
				st_wd = slot_rd;
			end
			S_RDONE: begin
				st_we = newblk_q && !stash_full;
				st_wd = {addr_q, wd_q};
			end
			S_SRCHK: begin
				st_we = match && act_q == ACT_WRITE;
				st_wa = wrap(head_q, srch_i_q);
				st_wd = {addr_q, wd_q};
			end
			S_EISS: fill_we = e_stop;
			S_EDEC: begin
				slot_we = fits;
				st_we   = !fits;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (st_we) stash_mem[st_wa] <= st_wd;
		stash_rd <= stash_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= e_q;
		slot_rd <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[ni] <= fill_wd;
		fill_rd <= fill_mem[ni];
	end

	// per-node valid bits stand in for the zeroed fill counts after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_TOTAL; i++) fill_vld_q[i] <= 1'b0;
			fill_v_rd <= 1'b0;
		end else begin
			if (fill_we) fill_vld_q[ni] <= 1'b1;
			fill_v_rd <= fill_vld_q[ni];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			head_q   <= '0;
			stored_q <= '0;
			peak_q   <= '0;
			cap_q    <= 10'd1020;
		end else begin
			if (capacity_we) cap_q <= capacity;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ADDRESS_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) state_q <= S_MAPRD;
				end
				S_MAPRD: state_q <= S_MAPCHK;
				S_MAPCHK: begin
					if (map_rd[LW]) begin
						node1_q <= {1'b1, map_rd[LW-1:0]};
						state_q <= S_RFILL;
					end else if (act_q != ACT_WRITE || stored_q >= cap_q) begin
						state_q <= S_DONE;
					end else begin
						node1_q <= {1'b1, dl_q};
						state_q <= S_RFILL;
					end
				end
				S_RFILL: state_q <= S_RCAP;
				S_RCAP: state_q <= S_RSLOT;
				S_RSLOT: begin
					if (slot_i_q < fill_cur_q) begin
						state_q <= S_RPUSH;
					end else if (node1_q == NW'(1)) begin
						state_q <= S_RDONE;
					end else begin
						node1_q <= node1_q >> 1;
						state_q <= S_RFILL;
					end
				end
				S_RPUSH: begin
					if (!stash_full) cnt_q <= cnt_q + CW'(1);
					state_q <= S_RSLOT;
				end
				S_RDONE: begin
					if (cnt_q > peak_q) peak_q <= cnt_q;
					if (newblk_q) begin
						if (!stash_full) cnt_q <= cnt_q + CW'(1);
						stored_q <= stored_q + 10'd1;
					end
					state_q <= S_MAPWR;
				end
				S_MAPWR: begin
					if (cnt_q > peak_q) peak_q <= cnt_q;
					state_q <= S_SRISS;
				end
				S_SRISS: begin
					if (srch_i_q < cnt_q) state_q <= S_SRCHK;
					else state_q <= S_DONE;
				end
				S_SRCHK: begin
					if (match) begin
						node1_q <= {1'b1, old_q};
						lvl_q   <= LVW'(LW);
						state_q <= S_EFILL;
					end else begin
						state_q <= S_SRISS;
					end
				end
				S_EFILL: state_q <= S_ECAP;
				S_ECAP: state_q <= S_EISS;
				S_EISS: begin
					if (!e_stop) begin
						state_q <= S_EMAP;
					end else if (node1_q != NW'(1)) begin
						node1_q <= node1_q >> 1;
						lvl_q   <= lvl_q - LVW'(1);
						state_q <= S_EFILL;
					end else if (!pass2_q) begin
						node1_q <= {1'b1, second_leaf};
						lvl_q   <= LVW'(LW);
						state_q <= S_EFILL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_EMAP: state_q <= S_EDEC;
				S_EDEC: begin
					// pop the front; a block that does not fit rotates to the back
					head_q <= wrap(head_q, CW'(1));
					if (fits) cnt_q <= cnt_q - CW'(1);
					state_q <= S_EISS;
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				{act_q, addr_q, wd_q, nl_q, dl_q, xl_q} <= q_data;
				newblk_q <= 1'b0;
				ovf_q    <= 1'b0;
				pass2_q  <= 1'b0;
				rdata_q  <= '0;
				status_q <= ST_OK;
				srch_i_q <= '0;
			end
			S_MAPCHK: begin
				if (map_rd[LW]) begin
					old_q <= map_rd[LW-1:0];
				end else if (act_q != ACT_WRITE) begin
					status_q <= ST_UNKNOWN;
				end else if (stored_q >= cap_q) begin
					status_q <= ST_FULL;
				end else begin
					old_q    <= dl_q;
					newblk_q <= 1'b1;
				end
			end
			S_RCAP: begin
				fill_cur_q <= fill_eff;
				slot_i_q   <= '0;
			end
			S_RPUSH: begin
				if (stash_full) ovf_q <= 1'b1;
				slot_i_q <= slot_i_q + FW'(1);
			end
			S_RDONE: begin
				if (newblk_q && stash_full) ovf_q <= 1'b1;
			end
			S_SRISS: begin
				if (srch_i_q >= cnt_q) begin
					status_q <= ST_OVERFLOW;
					rdata_q  <= '0;
				end
			end
			S_SRCHK: begin
				if (match) begin
					if (act_q != ACT_WRITE) rdata_q <= stash_rd[DATA_W-1:0];
				end else begin
					srch_i_q <= srch_i_q + CW'(1);
				end
			end
			S_ECAP: begin
				fill_cur_q <= fill_eff;
				drain_n_q  <= cnt_q;
				drain_i_q  <= '0;
			end
			S_EISS: begin
				if (e_stop && node1_q == NW'(1)) pass2_q <= 1'b1;
			end
			S_EMAP: e_q <= stash_rd;
			S_EDEC: begin
				drain_i_q <= drain_i_q + CW'(1);
				if (fits) fill_cur_q <= fill_cur_q + FW'(1);
			end
			S_FIN: begin
				if (ovf_q) status_q <= ST_OVERFLOW;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/path_oram_controller.sv
// path oram controller top: front, command queue and back sequencer
// depends on porc_pkg, porc_front, porc_queue, porc_back
//
//  channel   | handshake              | payload
//  command   | start / busy           | action address write_data new_leaf dummy_leaf extra_leaf
//  result    | done (one-cycle pulse) | read_data status stash_peak
//  capacity  | capacity_we            | capacity
//
// a command reads the path tree node by node and slot by slot, searches the stash
// entry by entry and examines the stash in each eviction node; a failed access ends
// after the position map check. after reset the position map is cleared entry by
// entry with busy high. the front holds one word and the queue two, so commands are
// taken while the back works. results cannot be stalled.
`default_nettype none

module path_oram_controller
	import porc_pkg::*;
#(
	parameter int unsigned TREE_LEVELS   = 8,
	parameter int unsigned BUCKET_SLOTS  = 4,
	parameter int unsigned STASH_DEPTH   = 64,
	parameter int unsigned ADDRESS_COUNT = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [9:0]         address,
	input  wire logic signed [31:0] write_data,
	input  wire logic [6:0]         new_leaf,
	input  wire logic [6:0]         dummy_leaf,
	input  wire logic [5:0]         extra_leaf,
	input  wire logic               capacity_we,
	input  wire logic [9:0]         capacity,
	output logic                    done,
	output logic signed [31:0]      read_data,
	output logic [1:0]              status,
	output logic [6:0]              stash_peak
);

	localparam int unsigned QW = 1 + $clog2(ADDRESS_COUNT) + DATA_W + 3 * (TREE_LEVELS - 1);

	back_stat_t    stat;
	logic          push, q_full, q_valid, q_pop;
	logic [QW-1:0] push_data, q_data;
	logic [31:0]   rdata;

	porc_front #(
		.TREE_LEVELS(TREE_LEVELS), .ADDRESS_COUNT(ADDRESS_COUNT), .QW(QW)
	) u_front (
		.clk, .arst_n, .start, .busy, .action, .address, .write_data,
		.new_leaf, .dummy_leaf, .extra_leaf, .stat,
		.push, .push_data, .q_full
	);

	porc_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop(q_pop), .valid(q_valid), .head_data(q_data)
	);

	porc_back #(
		.TREE_LEVELS(TREE_LEVELS), .BUCKET_SLOTS(BUCKET_SLOTS),
		.STASH_DEPTH(STASH_DEPTH), .ADDRESS_COUNT(ADDRESS_COUNT), .QW(QW)
	) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop, .capacity_we, .capacity,
		.stat, .rdata, .rstatus(status), .rpeak(stash_peak)
	);

	assign done      = stat.done;
	assign read_data = rdata;

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !stat.clearing)
		else $error("result during map clear");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_UNKNOWN || status == ST_FULL) |-> read_data == 32'sd0)
		else $error("failed access returned data");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result pulse longer than one cycle");

	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> busy)
		else $error("command taken during map clear");

endmodule

`default_nettype wire
